// ----- src/lltd_pkg.sv -----
`timescale 1ns / 1ps
package lltd_pkg;

  localparam int unsigned NumWorkersDefault = 8;
  localparam int unsigned QueueDepthDefault = 16;

  // Operation codes of an input transaction.
  localparam logic [1:0] OpSubmit   = 2'd0;
  localparam logic [1:0] OpFetch    = 2'd1;
  localparam logic [1:0] OpShutdown = 2'd2;
  localparam logic [1:0] OpStartup  = 2'd3;

  // Priority codes.
  localparam logic [1:0] PrioMiddle = 2'd1;
  localparam logic [1:0] PrioHead   = 2'd2;

  // Result status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRefused  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StInactive = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_HEAD,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_DONE
  } state_e;

endpackage

// ----- src/least_loaded_task_dispatcher_core.sv -----
`timescale 1ns / 1ps
// Steps: a shutdown, a startup or a fetch that pops nothing is decided and then returns its result.
// A fetch that pops reads the head, then moves each later entry forward by a read and a write. A
// submit scans one worker per cycle, decides and, if accepted, shifts each entry behind its slot by
// a read and a write before it puts the task. One transaction at a time: the input stalls until the
// result is taken and the block is idle again. Reset: queues empty, one worker active, accepting, max_workers 8.
module least_loaded_task_dispatcher_core #(
  parameter int unsigned NUM_WORKERS = lltd_pkg::NumWorkersDefault,
  parameter int unsigned QUEUE_DEPTH = lltd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] task_id_i,
  input  logic [1:0]  priority_req_i,
  input  logic [2:0]  worker_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  chosen_worker_o,
  output logic [15:0] task_out_o,
  output logic [3:0]  active_workers_o,
  output logic [4:0]  queue_level_o
);

  localparam int unsigned WW = $clog2(NUM_WORKERS);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = $clog2(NUM_WORKERS + 1);
  localparam int unsigned AW = WW + PW;
  localparam int unsigned RamDepth = 1 << AW;

  lltd_pkg::state_e state_q, state_d;

  logic [FW-1:0] fill_q [NUM_WORKERS];
  logic [TW-1:0] total_q, total_d;
  logic          stopped_q, stopped_d;
  logic [3:0]    maxw_q;

  logic [1:0]  op_q;
  logic [15:0] task_q;
  logic [1:0]  prio_q;
  logic [2:0]  req_q;

  // Scan registers.
  logic [TW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  logic [WW-1:0] best_q, best_d;
  logic [FW-1:0] bestf_q, bestf_d;

  // Move state.
  logic [WW-1:0] w_q, w_d;
  logic [FW-1:0] pos_q, pos_d;
  logic [FW-1:0] stop_q, stop_d;
  logic          pop_q, pop_d;

  logic [2:0]  st_q, st_d;
  logic [2:0]  ch_q, ch_d;
  logic [15:0] tout_q, tout_d;
  logic [4:0]  lvl_q, lvl_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  logic [TW-1:0] limit;
  logic          fill_we, fill_inc, fill_clr;

  logic          grow;
  logic [WW-1:0] sel_w;
  logic [FW-1:0] sel_fill;
  logic          fetch_ok;

  lltd_ram #(.Width(16), .Depth(RamDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_stall_o       = (state_q != lltd_pkg::S_IDLE);
  assign cfg_ready_o      = (state_q == lltd_pkg::S_IDLE);
  assign out_valid_o      = (state_q == lltd_pkg::S_DONE);
  assign status_o         = st_q;
  assign chosen_worker_o  = ch_q;
  assign task_out_o       = tout_q;
  assign active_workers_o = 4'(total_q);
  assign queue_level_o    = lvl_q;

  // Effective worker limit.
  always_comb begin
    if (maxw_q == 4'd0 || 32'(maxw_q) > NUM_WORKERS) begin
      limit = TW'(NUM_WORKERS);
    end else begin
      limit = TW'(maxw_q);
    end
  end

  // Worker picked by a submit once the scan is over, and whether a fetch can pop.
  always_comb begin
    grow     = !found_q && (total_q < limit);
    sel_w    = grow ? WW'(total_q) : best_q;
    sel_fill = grow ? '0 : fill_q[best_q];
    fetch_ok = (32'(req_q) < NUM_WORKERS) && (32'(req_q) < 32'(total_q))
               && (fill_q[WW'(req_q)] != '0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lltd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == lltd_pkg::OpSubmit) ? lltd_pkg::S_SCAN : lltd_pkg::S_DECIDE;
        end
      end
      lltd_pkg::S_SCAN: begin
        if (stopped_q || found_q || idx_q >= total_q) state_d = lltd_pkg::S_DECIDE;
      end
      lltd_pkg::S_DECIDE: begin
        state_d = lltd_pkg::S_DONE;
        if (op_q == lltd_pkg::OpSubmit && !stopped_q && 32'(sel_fill) < QUEUE_DEPTH) begin
          state_d = lltd_pkg::S_MOVE_RD;
        end
        if (op_q == lltd_pkg::OpFetch && fetch_ok) state_d = lltd_pkg::S_HEAD;
      end
      lltd_pkg::S_HEAD:    state_d = lltd_pkg::S_MOVE_RD;
      lltd_pkg::S_MOVE_RD: begin
        if (pop_q ? (pos_q >= stop_q) : (pos_q <= stop_q)) begin
          state_d = lltd_pkg::S_PUT;
        end else begin
          state_d = lltd_pkg::S_MOVE_WR;
        end
      end
      lltd_pkg::S_MOVE_WR: state_d = lltd_pkg::S_MOVE_RD;
      lltd_pkg::S_PUT:     state_d = lltd_pkg::S_DONE;
      lltd_pkg::S_DONE: begin
        if (!out_stall_i) state_d = lltd_pkg::S_IDLE;
      end
      default: state_d = lltd_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [FW-1:0] half;
    idx_d = idx_q; found_d = found_q; best_d = best_q; bestf_d = bestf_q;
    w_d = w_q; pos_d = pos_q; stop_d = stop_q; pop_d = pop_q;
    st_d = st_q; ch_d = ch_q; tout_d = tout_q; lvl_d = lvl_q;
    total_d = total_q; stopped_d = stopped_q;
    we = 1'b0; waddr = '0; wdata = task_q; raddr = '0;
    fill_we = 1'b0; fill_inc = 1'b0; fill_clr = 1'b0;
    half = '0;
    unique case (state_q)
      lltd_pkg::S_IDLE: begin
        idx_d = '0; found_d = 1'b0; best_d = '0; bestf_d = '1;
        st_d = lltd_pkg::StOk; ch_d = '0; tout_d = '0; lvl_d = '0;
      end
      lltd_pkg::S_SCAN: begin
        // One worker fill compared per cycle, first idle or least loaded.
        if (!found_q && idx_q < total_q) begin
          if (fill_q[WW'(idx_q)] == '0) begin
            found_d = 1'b1;
            best_d = WW'(idx_q);
          end else if (fill_q[WW'(idx_q)] < bestf_q) begin
            bestf_d = fill_q[WW'(idx_q)];
            best_d = WW'(idx_q);
          end
          idx_d = idx_q + TW'(1);
        end
      end
      lltd_pkg::S_DECIDE: begin
        pop_d = 1'b0;
        unique case (op_q)
          lltd_pkg::OpSubmit: begin
            if (stopped_q) begin
              st_d = lltd_pkg::StRefused;
            end else begin
              if (grow) total_d = total_q + TW'(1);
              w_d = sel_w;
              ch_d = 3'(sel_w);
              lvl_d = 5'(sel_fill);
              if (32'(sel_fill) >= QUEUE_DEPTH) st_d = lltd_pkg::StFull;
              half = sel_fill >> 1;
              if (prio_q == lltd_pkg::PrioHead) stop_d = '0;
              else if (prio_q == lltd_pkg::PrioMiddle && half != '0) stop_d = half - FW'(1);
              else stop_d = sel_fill;
              pos_d = sel_fill;
            end
          end
          lltd_pkg::OpFetch: begin
            ch_d = req_q;
            if (32'(req_q) >= NUM_WORKERS || 32'(req_q) >= 32'(total_q)) begin
              st_d = lltd_pkg::StInactive;
            end else if (fill_q[WW'(req_q)] == '0) begin
              st_d = lltd_pkg::StEmpty;
            end else begin
              // Read the head now; it lands in the next cycle.
              w_d = WW'(req_q);
              pop_d = 1'b1;
              pos_d = '0;
              stop_d = fill_q[WW'(req_q)] - FW'(1);
              raddr = {WW'(req_q), PW'(0)};
            end
          end
          lltd_pkg::OpShutdown: begin
            fill_clr = 1'b1;
            total_d = '0;
            stopped_d = 1'b1;
          end
          default: begin
            stopped_d = 1'b0;
            if (total_q == '0) total_d = TW'(1);
          end
        endcase
      end
      lltd_pkg::S_HEAD: begin
        tout_d = rdata;
      end
      lltd_pkg::S_MOVE_RD: begin
        // A pop pulls the next entry forward; an insert pushes the previous one back.
        if (pop_q) raddr = {w_q, PW'(pos_q + FW'(1))};
        else raddr = {w_q, PW'(pos_q - FW'(1))};
      end
      lltd_pkg::S_MOVE_WR: begin
        we = 1'b1;
        waddr = {w_q, PW'(pos_q)};
        wdata = rdata;
        if (pop_q) pos_d = pos_q + FW'(1);
        else pos_d = pos_q - FW'(1);
      end
      lltd_pkg::S_PUT: begin
        fill_we = 1'b1;
        if (pop_q) begin
          lvl_d = 5'(fill_q[w_q] - FW'(1));
        end else begin
          we = 1'b1;
          waddr = {w_q, PW'(stop_q)};
          wdata = task_q;
          fill_inc = 1'b1;
          lvl_d = 5'(fill_q[w_q] + FW'(1));
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lltd_pkg::S_IDLE;
      total_q   <= TW'(1);
      stopped_q <= 1'b0;
      maxw_q    <= 4'd8;
      for (int i = 0; i < NUM_WORKERS; i++) fill_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      stopped_q <= stopped_d;
      if (cfg_valid_i && cfg_ready_o) maxw_q <= cfg_data_i;
      if (fill_clr) begin
        for (int i = 0; i < NUM_WORKERS; i++) fill_q[i] <= '0;
      end else if (fill_we) begin
        fill_q[w_q] <= fill_inc ? fill_q[w_q] + FW'(1) : fill_q[w_q] - FW'(1);
      end
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    if (state_q == lltd_pkg::S_IDLE && in_valid_i) begin
      op_q <= op_i; task_q <= task_id_i; prio_q <= priority_req_i; req_q <= worker_i;
    end
    idx_q <= idx_d; found_q <= found_d; best_q <= best_d; bestf_q <= bestf_d;
    w_q <= w_d; pos_q <= pos_d; stop_q <= stop_d; pop_q <= pop_d;
    st_q <= st_d; ch_q <= ch_d; tout_q <= tout_d; lvl_q <= lvl_d;
  end

endmodule

// ----- src/lltd_ram.sv -----
`timescale 1ns / 1ps
module lltd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int NW = 8;
  localparam int QD = 16;
  localparam int RandItems = 1300;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] task_id;
    logic [1:0]  prio;
    logic [2:0]  worker;
  } job_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  chosen;
    logic [15:0] task_out;
    logic [3:0]  active;
    logic [4:0]  level;
  } outcome_t;

  // One row of the directed table: the transaction, and optionally its known result.
  typedef struct packed {
    job_t     job;
    logic     fixed;
    outcome_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [15:0] task_id_i = '0;
  logic [1:0]  priority_req_i = '0;
  logic [2:0]  worker_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [2:0]  chosen_worker_o;
  logic [15:0] task_out_o;
  logic [3:0]  active_workers_o;
  logic [4:0]  queue_level_o;

  least_loaded_task_dispatcher_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state of the dispatcher.
  logic [15:0] queue_mem [NW][QD];
  int unsigned queue_cnt [NW];
  int unsigned live_workers;
  bit          halted;
  logic [3:0]  limit_reg;

  outcome_t pending_results[$];
  int       errors = 0;
  bit       hold_off = 1'b0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned worker_cap();
    if (limit_reg == 0 || limit_reg > NW) return NW;
    return limit_reg;
  endfunction

  function automatic int unsigned choose_worker();
    int unsigned best = 0;
    int unsigned best_cnt = 32'hffff_ffff;
    for (int unsigned i = 0; i < live_workers; i++)
      if (queue_cnt[i] == 0) return i;
    if (live_workers < worker_cap()) begin
      live_workers++;
      return live_workers - 1;
    end
    for (int unsigned i = 0; i < live_workers; i++)
      if (queue_cnt[i] < best_cnt) begin
        best_cnt = queue_cnt[i];
        best = i;
      end
    return best;
  endfunction

  function automatic void place_task(int unsigned w, int unsigned pos, logic [15:0] id);
    for (int unsigned i = queue_cnt[w]; i > pos; i--) queue_mem[w][i] = queue_mem[w][i-1];
    queue_mem[w][pos] = id;
    queue_cnt[w]++;
  endfunction

  function automatic outcome_t dispatch(job_t j);
    outcome_t r = '0;
    int unsigned w, f;
    case (j.op)
      lltd_pkg::OpSubmit: begin
        if (halted) r.status = lltd_pkg::StRefused;
        else begin
          w = choose_worker();
          f = queue_cnt[w];
          r.chosen = w[2:0];
          if (f >= QD) r.status = lltd_pkg::StFull;
          else if (j.prio == lltd_pkg::PrioHead) place_task(w, 0, j.task_id);
          else if (j.prio == lltd_pkg::PrioMiddle && (f >> 1) != 0)
            place_task(w, (f >> 1) - 1, j.task_id);
          else place_task(w, f, j.task_id);
          r.level = queue_cnt[w][4:0];
        end
      end
      lltd_pkg::OpFetch: begin
        r.chosen = j.worker;
        if (j.worker >= live_workers) r.status = lltd_pkg::StInactive;
        else if (queue_cnt[j.worker] == 0) r.status = lltd_pkg::StEmpty;
        else begin
          r.task_out = queue_mem[j.worker][0];
          for (int unsigned i = 1; i < queue_cnt[j.worker]; i++)
            queue_mem[j.worker][i-1] = queue_mem[j.worker][i];
          queue_cnt[j.worker]--;
          r.level = queue_cnt[j.worker][4:0];
        end
      end
      lltd_pkg::OpShutdown: begin
        for (int i = 0; i < NW; i++) queue_cnt[i] = 0;
        live_workers = 0;
        halted = 1'b1;
      end
      default: begin
        halted = 1'b0;
        if (live_workers == 0) live_workers = 1;
      end
    endcase
    r.active = live_workers[3:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one transaction, queues its expected result, then idles for a random gap.
  task automatic send(input job_t j, input bit fixed, input outcome_t want);
    outcome_t p;
    int gap;
    in_valid_i <= 1'b1;
    op_i <= j.op;
    task_id_i <= j.task_id;
    priority_req_i <= j.prio;
    worker_i <= j.worker;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = dispatch(j);
    if (fixed && p != want) report("table row", 1, 0);
    pending_results.push_back(fixed ? want : p);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops the input request after the last transaction of a sequence.
  task automatic stop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [3:0] v);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    limit_reg = v;
  endtask

  function automatic job_t rand_job();
    job_t j;
    int p = $urandom_range(0, 99);
    j.task_id = 16'($urandom);
    j.prio = 2'($urandom_range(0, 3));
    j.worker = 3'($urandom_range(0, 7));
    if (p < 52) j.op = lltd_pkg::OpSubmit;
    else if (p < 94) j.op = lltd_pkg::OpFetch;
    else if (p < 97) j.op = lltd_pkg::OpShutdown;
    else j.op = lltd_pkg::OpStartup;
    return j;
  endfunction

  // Result checking, with random stalls on the output side.
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {status_o, chosen_worker_o, task_out_o, active_workers_o, queue_level_o};
        if (pending_results.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.chosen !== want.chosen) report("chosen_worker", got.chosen, want.chosen);
          if (got.task_out !== want.task_out) report("task_out", got.task_out, want.task_out);
          if (got.active !== want.active) report("active_workers", got.active, want.active);
          if (got.level !== want.level) report("queue_level", got.level, want.level);
        end
      end
      out_stall_i <= hold_off || ($urandom_range(0, 99) < 25);
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  initial begin
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t rows[$];
    job_t j;
    outcome_t none;
    logic [3:0] lims [6];
    none = '0;
    lims = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd3, 4'd1};
    for (int i = 0; i < NW; i++) queue_cnt[i] = 0;
    live_workers = 1;
    halted = 1'b0;
    limit_reg = 4'd8;
    // Directed table: {op, task, prio, worker}, fixed flag, {status, chosen, task, active, level}.
    rows.push_back('{'{lltd_pkg::OpFetch, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StEmpty, 3'd0, 16'h0, 4'd1, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpFetch, 16'h0, 2'd0, 3'd7}, 1'b1,
                     '{lltd_pkg::StInactive, 3'd7, 16'h0, 4'd1, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpSubmit, 16'hffff, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'h0, 4'd1, 5'd1}});
    rows.push_back('{'{lltd_pkg::OpSubmit, 16'h0000, 2'd2, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd1, 16'h0, 4'd2, 5'd1}});
    rows.push_back('{'{lltd_pkg::OpSubmit, 16'h1234, 2'd1, 3'd0}, 1'b0, none});
    rows.push_back('{'{lltd_pkg::OpSubmit, 16'h5555, 2'd3, 3'd7}, 1'b0, none});
    rows.push_back('{'{lltd_pkg::OpFetch, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'hffff, 4'd4, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpShutdown, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'h0, 4'd0, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpShutdown, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'h0, 4'd0, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpSubmit, 16'haaaa, 2'd2, 3'd0}, 1'b1,
                     '{lltd_pkg::StRefused, 3'd0, 16'h0, 4'd0, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpFetch, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StInactive, 3'd0, 16'h0, 4'd0, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpStartup, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'h0, 4'd1, 5'd0}});
    rows.push_back('{'{lltd_pkg::OpStartup, 16'h0, 2'd0, 3'd0}, 1'b1,
                     '{lltd_pkg::StOk, 3'd0, 16'h0, 4'd1, 5'd0}});
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send(rows[i].job, rows[i].fixed, rows[i].want);

    // Limit of one: fill worker 0 past its depth, mixing priorities, then drain.
    write_limit(4'd1);
    for (int i = 0; i < QD + 2; i++) begin
      j = '{lltd_pkg::OpSubmit, 16'(i * 977), 2'(i % 3), 3'd0};
      send(j, 1'b0, none);
    end
    for (int i = 0; i < QD + 1; i++) begin
      j = '{lltd_pkg::OpFetch, 16'h0, 2'd0, 3'd0};
      send(j, 1'b0, none);
    end

    // Random phases under several limits, extremes included; 0 means unlimited.
    foreach (lims[k]) begin
      write_limit(lims[k]);
      for (int i = 0; i < RandItems / 6; i++) send(rand_job(), 1'b0, none);
    end

    stop_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
